// ===== src/psf_pkg.sv =====
// ----------------------------------------------------------------------------
// psf_pkg
// Shared types, constants and helpers of the padded S-record formatter.
// ----------------------------------------------------------------------------
package psf_pkg;

  // Default record payload size in bytes (1..128)
  localparam int RecordBytesDef = 128;
  // Depth of the job queue between front and back
  localparam int QueueDepthDef  = 2;

  // Characters in front of the zero run: "S2" LL AAAAAA DD
  localparam int PrefixChars = 12;
  localparam int SuffixChars = 2;
  // Counts of characters in one line, sized for the largest record size
  localparam int LenW        = 9;
  localparam int WordChars   = 8;

  localparam logic [7:0] CharS    = 8'h53;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharTwo  = 8'h32;
  localparam logic [7:0] CharNine = 8'h39;

  typedef enum logic [1:0] {
    OP_DATA   = 2'd0,
    OP_HEADER = 2'd1,
    OP_TERM   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // One line of output: prefix chars, a run of '0', an optional two-char suffix
  typedef struct packed {
    logic [0:PrefixChars-1][7:0] prefix;
    logic [3:0]                  pre_len;
    logic [LenW-1:0]             zeros;
    logic [0:SuffixChars-1][7:0] suffix;
    logic                        has_suffix;
    logic                        ends_record;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'h0, nib};
    end else begin
      r = 8'h37 + {4'h0, nib};
    end
    return r;
  endfunction

endpackage

// ===== src/psf_front.sv =====
// ----------------------------------------------------------------------------
// psf_front
// Accepts input words, tracks the open record and builds one line job per
// word: prefix characters, zero padding length, checksum suffix at close.
// ----------------------------------------------------------------------------
module psf_front #(
  parameter int RecordBytes = psf_pkg::RecordBytesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    op_i,
  input  logic [7:0]    data_byte_i,
  input  logic [23:0]   load_address_i,
  input  logic [7:0]    record_length_i,
  input  logic          q_full_i,
  output logic          push_o,
  output psf_pkg::job_t job_o
);

  localparam logic [7:0] RecLen = 8'(RecordBytes);
  localparam logic [psf_pkg::LenW-1:0] SpecialZeros = psf_pkg::LenW'(2 * RecordBytes + 10);

  logic [7:0] left_q, left_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] pad_q, pad_d;

  logic          accept;
  psf_pkg::op_e  op;
  logic          first;
  logic [7:0]    len_eff;
  logic [7:0]    len_m1;
  logic [7:0]    blen;
  logic [7:0]    new_left;
  logic [7:0]    sum_new;
  logic [7:0]    pad_cur;
  psf_pkg::job_t job;
  logic          push;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign op         = psf_pkg::op_e'(op_i);

  always_comb begin
    priority if (record_length_i == 8'd0) begin
      len_eff = 8'd1;
    end else if (record_length_i > RecLen) begin
      len_eff = RecLen;
    end else begin
      len_eff = record_length_i;
    end
  end

  assign first    = (left_q == 8'd0);
  assign len_m1   = len_eff - 8'd1;
  assign blen     = first ? len_eff : left_q;
  assign new_left = blen - 8'd1;
  assign sum_new  = (first ? 8'd0 : sum_q) + data_byte_i;
  assign pad_cur  = first ? (RecLen - len_eff) : pad_q;

  always_comb begin
    job         = '0;
    push        = 1'b0;
    left_d      = left_q;
    sum_d       = sum_q;
    pad_d       = pad_q;
    unique case (op)
      psf_pkg::OP_DATA: begin
        push = accept;
        if (first) begin
          job.prefix = {psf_pkg::CharS, psf_pkg::CharTwo,
                        psf_pkg::hex_char(len_m1[7:4]), psf_pkg::hex_char(len_m1[3:0]),
                        psf_pkg::hex_char(load_address_i[23:20]),
                        psf_pkg::hex_char(load_address_i[19:16]),
                        psf_pkg::hex_char(load_address_i[15:12]),
                        psf_pkg::hex_char(load_address_i[11:8]),
                        psf_pkg::hex_char(load_address_i[7:4]),
                        psf_pkg::hex_char(load_address_i[3:0]),
                        psf_pkg::hex_char(data_byte_i[7:4]),
                        psf_pkg::hex_char(data_byte_i[3:0])};
          job.pre_len = 4'(psf_pkg::PrefixChars);
        end else begin
          job.prefix[0] = psf_pkg::hex_char(data_byte_i[7:4]);
          job.prefix[1] = psf_pkg::hex_char(data_byte_i[3:0]);
          job.pre_len   = 4'd2;
        end
        if (new_left == 8'd0) begin
          // record closes: pad, then checksum of data bytes
          job.zeros       = {pad_cur, 1'b0};
          job.suffix      = {psf_pkg::hex_char(sum_new[7:4]),
                             psf_pkg::hex_char(sum_new[3:0])};
          job.has_suffix  = 1'b1;
          job.ends_record = 1'b1;
          if (accept) begin
            left_d = 8'd0;
            sum_d  = 8'd0;
            pad_d  = 8'd0;
          end
        end else if (accept) begin
          left_d = new_left;
          sum_d  = sum_new;
          pad_d  = pad_cur;
        end
      end
      psf_pkg::OP_HEADER, psf_pkg::OP_TERM: begin
        push             = accept;
        job.prefix[0]    = psf_pkg::CharS;
        job.prefix[1]    = (op == psf_pkg::OP_HEADER) ? psf_pkg::CharZero : psf_pkg::CharNine;
        job.pre_len      = 4'd2;
        job.zeros        = SpecialZeros;
        job.ends_record  = 1'b1;
        if (accept) begin
          left_d = 8'd0;
          sum_d  = 8'd0;
          pad_d  = 8'd0;
        end
      end
      psf_pkg::OP_NONE: begin
        push = 1'b0;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 8'd0;
      sum_q  <= 8'd0;
      pad_q  <= 8'd0;
    end else begin
      left_q <= left_d;
      sum_q  <= sum_d;
      pad_q  <= pad_d;
    end
  end

  assign push_o = push;
  assign job_o  = job;

endmodule

// ===== src/psf_queue.sv =====
// ----------------------------------------------------------------------------
// psf_queue
// Small job FIFO between the front and the back of the formatter.
// ----------------------------------------------------------------------------
module psf_queue #(
  parameter int Depth = psf_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  psf_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output psf_pkg::job_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  psf_pkg::job_t       entries_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entries_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== src/psf_back.sv =====
// ----------------------------------------------------------------------------
// psf_back
// Walks the head job's character line eight characters per cycle unless stalled
// and holds each packed word in the output register until it is taken.
// ----------------------------------------------------------------------------
module psf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  psf_pkg::job_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [63:0]   chars_o,
  output logic [3:0]    char_count_o,
  output logic          item_done_o,
  output logic          record_end_o
);

  localparam int LenW = psf_pkg::LenW;

  logic [LenW-1:0] pos_q, pos_d;
  logic            valid_q, valid_d;
  logic [63:0]     chars_q;
  logic [3:0]      count_q;
  logic            done_q;
  logic            rec_end_q;

  logic            advance;
  logic [LenW-1:0] pre_end, zero_end, total, remain;
  logic            last;
  logic [3:0]      word_count;
  logic [63:0]     word;
  logic [LenW-1:0] p;
  logic [LenW-1:0] sidx;

  assign pre_end  = LenW'(head_i.pre_len);
  assign zero_end = pre_end + head_i.zeros;
  assign total    = zero_end + (head_i.has_suffix ? LenW'(psf_pkg::SuffixChars) : '0);
  assign remain   = total - pos_q;
  assign last     = (remain <= LenW'(psf_pkg::WordChars));
  assign word_count = last ? remain[3:0] : 4'(psf_pkg::WordChars);

  assign advance = head_valid_i && (!valid_q || !out_stall_i);
  assign pop_o   = advance && last;

  always_comb begin
    word = '0;
    p    = '0;
    sidx = '0;
    for (int i = 0; i < psf_pkg::WordChars; i++) begin
      p    = pos_q + LenW'(i);
      sidx = p - zero_end;
      if (p < pre_end) begin
        word[63 - 8*i -: 8] = head_i.prefix[p[3:0]];
      end else if (p < zero_end) begin
        word[63 - 8*i -: 8] = psf_pkg::CharZero;
      end else if (p < total) begin
        word[63 - 8*i -: 8] = head_i.suffix[sidx[0]];
      end
    end
  end

  always_comb begin
    pos_d   = pos_q;
    valid_d = valid_q;
    if (advance) begin
      valid_d = 1'b1;
      pos_d   = last ? '0 : pos_q + LenW'(psf_pkg::WordChars);
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      chars_q   <= word;
      count_q   <= word_count;
      done_q    <= last;
      rec_end_q <= last && head_i.ends_record;
    end
  end

  assign out_valid_o  = valid_q;
  assign chars_o      = chars_q;
  assign char_count_o = count_q;
  assign item_done_o  = done_q;
  assign record_end_o = rec_end_q;

endmodule

// ===== src/padded_srecord_formatter.sv =====
// ----------------------------------------------------------------------------
// padded_srecord_formatter
// Path: an accepted item is written into the job queue, then its first word is
//   registered in the output register of the back. One 8-char word per cycle
//   leaves the back unless stalled; an item is ceil(chars/8) words: middle byte
//   2 chars, record open 12, close or header/terminate up to 2*RecordBytes+12.
// Reset: asynchronous active low; clears record state, job queue, output valid.
// ----------------------------------------------------------------------------
module padded_srecord_formatter #(
  parameter int RecordBytes = psf_pkg::RecordBytesDef,
  parameter int QueueDepth  = psf_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  data_byte_i,
  input  logic [23:0] load_address_i,
  input  logic [7:0]  record_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] chars_o,
  output logic [3:0]  char_count_o,
  output logic        item_done_o,
  output logic        record_end_o
);

  logic          q_full;
  logic          push;
  psf_pkg::job_t job;
  logic          pop;
  logic          head_valid;
  psf_pkg::job_t head;

  psf_front #(
    .RecordBytes(RecordBytes)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .data_byte_i    (data_byte_i),
    .load_address_i (load_address_i),
    .record_length_i(record_length_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .job_o          (job)
  );

  psf_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .job_i       (job),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  psf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .chars_o     (chars_o),
    .char_count_o(char_count_o),
    .item_done_o (item_done_o),
    .record_end_o(record_end_o)
  );

  // a word that does not finish its item is always full
  a_full_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !item_done_o) |-> (char_count_o == 4'd8))
    else $error("short word before end of item");

  a_rec_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && record_end_o) |-> item_done_o)
    else $error("record end without item done");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_count_o != 4'd0 && char_count_o <= 4'd8))
    else $error("char count out of range");

  // queue pops only when it holds a job
  a_pop_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule
